// File: hdl/bsvc_pkg.sv
// Shared constants, types and helpers for the bounding sphere view cull block.
// Used by bsvc_div and bounding_sphere_view_cull; depends on nothing else.
package bsvc_pkg;

   // Fraction bits of the internal fixed-point words.
   localparam int FRAC_BITS = 16;

   // Width of a homogeneous coordinate (sum of three Q8.8 products plus w term).
   localparam int HW = 34;

   // Quotient bits resolved per divider stage, and stage count.
   localparam int DIV_BPS   = 2;
   localparam int DIV_STEPS = 32 / DIV_BPS;
   // Prepare stage, iteration stages and the saturation stage.
   localparam int DIV_LAT   = DIV_STEPS + 2;

   // Root bits resolved per square root stage, and stage count.
   localparam int SQ_BPS    = 2;
   localparam int SQ_STAGES = 32 / SQ_BPS;

   // Positions in the back end delay line.
   localparam int POS_H  = SQ_STAGES + 3;
   localparam int POS_J  = SQ_STAGES + 5;
   localparam int TAIL_N = SQ_STAGES + 6;

   // Q8.8 one as a shift.
   localparam int Q88_SHIFT = 8;

   localparam int NUM_FACES = 6;

   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_CULL_ENABLE = 1'b0;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      FACE_NEG_X = 3'd0,
      FACE_POS_X = 3'd1,
      FACE_NEG_Y = 3'd2,
      FACE_POS_Y = 3'd3,
      FACE_NEG_Z = 3'd4,
      FACE_POS_Z = 3'd5,
      FACE_NONE  = 3'd6
   } face_type;

   // What travels beside the arithmetic after the divide.
   typedef struct packed {
      logic             v;
      logic [15:0]      rad;
      logic [2:0][31:0] ctr;
   } tail_type;

   // Clamp a 33-bit signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat33(input logic signed [32:0] val);
      logic signed [31:0] res;
      if (val[32] != val[31]) begin
         res = val[32] ? S32_MIN : S32_MAX;
      end else begin
         res = val[31:0];
      end
      return res;
   endfunction

endpackage

// File: hdl/bsvc_div.sv
// Pipelined saturating divide of a homogeneous coordinate by w, giving a Q16.16 word.
// Depends on bsvc_pkg.
module bsvc_div (
   input  logic                             clock,
   input  logic                             advance,
   input  logic signed [bsvc_pkg::HW-1:0]   num,
   input  logic signed [bsvc_pkg::HW-1:0]   den,
   output logic signed [31:0]               quo
);
   import bsvc_pkg::*;

   localparam int NW = HW + FRAC_BITS;

   logic [HW-1:0] mag_in;
   logic [NW-1:0] numer_in;
   logic          big_in;
   logic          wbad_in;

   logic [HW:0]   rem_ff  [0:DIV_STEPS];
   logic [31:0]   low_ff  [0:DIV_STEPS];
   logic [31:0]   q_ff    [0:DIV_STEPS];
   logic [HW-1:0] dv_ff   [0:DIV_STEPS];
   logic          neg_ff  [0:DIV_STEPS];
   logic          wbad_ff [0:DIV_STEPS];
   logic          big_ff  [0:DIV_STEPS];

   logic signed [31:0] quo_in;
   logic signed [31:0] quo_ff;

   // A quotient of 2^32 or more is flagged here and saturated at the end.
   always_comb begin
      wbad_in  = (den <= 0);
      mag_in   = num[HW-1] ? HW'(-num) : HW'(num);
      numer_in = {mag_in, FRAC_BITS'(0)};
      big_in   = ((HW + 32)'(numer_in) >= {HW'(den), 32'd0});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= (HW + 1)'(numer_in[NW-1:32]);
         low_ff[0]  <= numer_in[31:0];
         q_ff[0]    <= '0;
         dv_ff[0]   <= HW'(den);
         neg_ff[0]  <= num[HW-1];
         wbad_ff[0] <= wbad_in;
         big_ff[0]  <= big_in;
      end
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [HW:0] rem_in;
      logic [31:0] low_in;
      logic [31:0] q_in;

      always_comb begin
         rem_in = rem_ff[g];
         low_in = low_ff[g];
         q_in   = q_ff[g];
         for (int j = 0; j < DIV_BPS; j++) begin
            rem_in = {rem_in[HW-1:0], low_in[31]};
            low_in = {low_in[30:0], 1'b0};
            if (rem_in >= {1'b0, dv_ff[g]}) begin
               rem_in = rem_in - {1'b0, dv_ff[g]};
               q_in   = {q_in[30:0], 1'b1};
            end else begin
               q_in   = {q_in[30:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g+1]  <= rem_in;
            low_ff[g+1]  <= low_in;
            q_ff[g+1]    <= q_in;
            dv_ff[g+1]   <= dv_ff[g];
            neg_ff[g+1]  <= neg_ff[g];
            wbad_ff[g+1] <= wbad_ff[g];
            big_ff[g+1]  <= big_ff[g];
         end
      end
   end

   always_comb begin
      if (wbad_ff[DIV_STEPS]) begin
         quo_in = S32_MAX;
      end else if (neg_ff[DIV_STEPS]) begin
         if (big_ff[DIV_STEPS] || (q_ff[DIV_STEPS] > 32'h8000_0000)) begin
            quo_in = S32_MIN;
         end else begin
            quo_in = 32'(-q_ff[DIV_STEPS]);
         end
      end else if (big_ff[DIV_STEPS] || q_ff[DIV_STEPS][31]) begin
         quo_in = S32_MAX;
      end else begin
         quo_in = q_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

// File: hdl/bounding_sphere_view_cull.sv
// Top level of the bounding sphere view cull block: pipeline, square roots, face test, CSR.
// Depends on bsvc_pkg and bsvc_div.
//
//  Channel | Ports                       | Direction | Transfer when
//  --------+-----------------------------+-----------+------------------------------
//  request | req_valid/req_stall, fields | in        | req_valid high, req_stall low
//  result  | rsp_valid/rsp_stall, fields | out       | rsp_valid high, rsp_stall low
//  config  | csr_psel .. csr_pready      | in/out    | psel, penable, pwrite high
//
// One object enters per cycle unless the pipeline is frozen. With the default
// constants a result passes three front stages, the 18-stage divider, three
// stages of differences, squares and sums, 16 square root stages, three stages
// for the largest length and the radius product, and the output register.
// The whole pipeline moves as one and freezes while a result waits under
// rsp_stall; req_stall follows that freeze. Reset is synchronous and clears
// the valid bits and sets cull_enable.
module bounding_sphere_view_cull (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [63:0]                  req_matrix_row_0,
   input  logic [63:0]                  req_matrix_row_1,
   input  logic [63:0]                  req_matrix_row_2,
   input  logic [63:0]                  req_matrix_row_3,
   input  logic signed [15:0]           req_center_x,
   input  logic signed [15:0]           req_center_y,
   input  logic signed [15:0]           req_center_z,
   input  logic [15:0]                  req_sphere_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_visible,
   output logic [2:0]                   rsp_cull_face,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsvc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import bsvc_pkg::*;

   localparam logic signed [HW-1:0] ONE_Q = HW'(1) << FRAC_BITS;

   // All pipeline registers advance together unless a finished result is held.
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Configuration register.
   logic cull_en_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cull_en_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_AW-1] == CSR_IDX_CULL_ENABLE)) begin
         cull_en_ff <= csr_pwdata[0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == CSR_IDX_CULL_ENABLE) ?
                       {31'd0, cull_en_ff} : 32'd0;

   // Stage 0: unpack the matrix rows into Q8.8 entries.
   logic [63:0]        row_in [0:3];
   logic signed [15:0] m_ff   [0:3][0:3];
   logic signed [15:0] cen_ff [0:2];
   logic [15:0]        rad0_ff;
   logic               v0_ff;

   assign row_in[0] = req_matrix_row_0;
   assign row_in[1] = req_matrix_row_1;
   assign row_in[2] = req_matrix_row_2;
   assign row_in[3] = req_matrix_row_3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               m_ff[r][c] <= row_in[r][16*c +: 16];
            end
         end
         cen_ff[0] <= req_center_x;
         cen_ff[1] <= req_center_y;
         cen_ff[2] <= req_center_z;
         rad0_ff   <= req_sphere_radius;
      end
   end

   // Stage 1: center products and the axis sums (unit axis plus translation).
   logic signed [31:0] pc_in  [0:3][0:2];
   logic signed [16:0] sa_in  [0:3][0:2];
   logic signed [31:0] pc_ff  [0:3][0:2];
   logic signed [16:0] sa_ff  [0:3][0:2];
   logic signed [15:0] m3_ff  [0:3];
   logic [15:0]        rad1_ff;
   logic               v1_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            pc_in[r][c] = m_ff[r][c] * cen_ff[c];
            sa_in[r][c] = 17'(m_ff[r][c]) + 17'(m_ff[r][3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff   <= pc_in;
         sa_ff   <= sa_in;
         for (int r = 0; r < 4; r++) begin
            m3_ff[r] <= m_ff[r][3];
         end
         rad1_ff <= rad0_ff;
      end
   end

   // Stage 2: homogeneous coordinates of the origin, the three unit axis
   // points and the sphere center. Row 3 of each point is its w.
   logic signed [HW-1:0] hp_in [0:4][0:3];
   logic signed [HW-1:0] hp_ff [0:4][0:3];
   logic [15:0]          rad2_ff;
   logic                 v2_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         hp_in[0][r] = HW'(m3_ff[r]) <<< Q88_SHIFT;
         for (int i = 0; i < 3; i++) begin
            hp_in[i+1][r] = HW'(sa_ff[r][i]) <<< Q88_SHIFT;
         end
         hp_in[4][r] = HW'(pc_ff[r][0]) + HW'(pc_ff[r][1]) + HW'(pc_ff[r][2]) +
                       (HW'(m3_ff[r]) <<< Q88_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hp_ff   <= hp_in;
         rad2_ff <= rad1_ff;
      end
   end

   // Fifteen dividers run side by side: x, y and z of each of five points.
   logic signed [31:0] qd [0:4][0:2];

   for (genvar p = 0; p < 5; p++) begin : g_pt
      for (genvar k = 0; k < 3; k++) begin : g_crd
         bsvc_div u_div (
            .clock   (clock),
            .advance (adv),
            .num     (hp_ff[p][k]),
            .den     (hp_ff[p][3]),
            .quo     (qd[p][k])
         );
      end
   end

   // Valid bits and radii keep pace with the dividers.
   logic        dv_ff   [0:DIV_LAT-1];
   logic [15:0] drad_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_LAT; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= v2_ff;
         for (int s = 1; s < DIV_LAT; s++) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drad_ff[0] <= rad2_ff;
         for (int s = 1; s < DIV_LAT; s++) begin
            drad_ff[s] <= drad_ff[s-1];
         end
      end
   end

   // Back end delay line: valid, radius and projected center ride along.
   tail_type tail_in;
   tail_type tail_ff [0:TAIL_N-1];

   always_comb begin
      tail_in.v   = dv_ff[DIV_LAT-1];
      tail_in.rad = drad_ff[DIV_LAT-1];
      for (int k = 0; k < 3; k++) begin
         tail_in.ctr[k] = qd[4][k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TAIL_N; s++) begin
            tail_ff[s] <= '0;
         end
      end else if (adv) begin
         tail_ff[0] <= tail_in;
         for (int s = 1; s < TAIL_N; s++) begin
            tail_ff[s] <= tail_ff[s-1];
         end
      end
   end

   // Stage E: axis image minus origin image, clamped.
   logic signed [31:0] d_in [0:2][0:2];
   logic signed [31:0] d_ff [0:2][0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            d_in[i][k] = sat33(33'(qd[i+1][k]) - 33'(qd[0][k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
      end
   end

   // Stage F: squares.
   logic [63:0] sq_in [0:2][0:2];
   logic [63:0] sq_ff [0:2][0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            sq_in[i][k] = 64'(d_ff[i][k] * d_ff[i][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
      end
   end

   // Stage G feeds the square root pipeline; index 0 holds the sums.
   logic [63:0] sv_ff   [0:SQ_STAGES][0:2];
   logic [35:0] srem_ff [0:SQ_STAGES][0:2];
   logic [31:0] root_ff [0:SQ_STAGES][0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sv_ff[0][i]   <= sq_ff[i][0] + sq_ff[i][1] + sq_ff[i][2];
            srem_ff[0][i] <= '0;
            root_ff[0][i] <= '0;
         end
      end
   end

   // Digit-by-digit square root, two radicand bits per root bit.
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [63:0] sv_in;
         logic [35:0] srem_in;
         logic [31:0] root_in;
         logic [35:0] trial;

         always_comb begin
            sv_in   = sv_ff[g][i];
            srem_in = srem_ff[g][i];
            root_in = root_ff[g][i];
            trial   = '0;
            for (int j = 0; j < SQ_BPS; j++) begin
               srem_in = {srem_in[33:0], sv_in[63:62]};
               sv_in   = {sv_in[61:0], 2'b00};
               trial   = {2'b00, root_in, 2'b01};
               if (srem_in >= trial) begin
                  srem_in = srem_in - trial;
                  root_in = {root_in[30:0], 1'b1};
               end else begin
                  root_in = {root_in[30:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               sv_ff[g+1][i]   <= sv_in;
               srem_ff[g+1][i] <= srem_in;
               root_ff[g+1][i] <= root_in;
            end
         end
      end
   end

   // Stage H: clamp each length and keep the largest.
   logic [30:0] len_in [0:2];
   logic [30:0] maxlen_in;
   logic [30:0] maxlen_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         len_in[i] = root_ff[SQ_STAGES][i][31] ? 31'h7FFF_FFFF :
                     root_ff[SQ_STAGES][i][30:0];
      end
      maxlen_in = len_in[0];
      if (len_in[1] > maxlen_in) begin
         maxlen_in = len_in[1];
      end
      if (len_in[2] > maxlen_in) begin
         maxlen_in = len_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         maxlen_ff <= maxlen_in;
      end
   end

   // Stage I: object radius times largest axis length.
   logic [46:0] prod_in;
   logic [46:0] prod_ff;

   assign prod_in = 47'(tail_ff[POS_H].rad) * 47'(maxlen_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   // Stage J: drop the Q8.8 scale and clamp.
   logic [30:0] radius_in;
   logic [30:0] radius_ff;

   assign radius_in = (prod_ff[46:39] != 8'd0) ? 31'h7FFF_FFFF : prod_ff[38:8];

   always_ff @(posedge clock) begin
      if (adv) begin
         radius_ff <= radius_in;
      end
   end

   // Output stage: when cull_enable is set, test the faces in order; a face that
   // the sphere straddles is skipped, and the first face with the center beyond it culls.
   logic               vis_in;
   face_type           face_in;
   logic               found;
   logic signed [HW-1:0] cc;
   logic signed [HW-1:0] rr;
   logic signed [HW-1:0] bound;
   logic               cull_hit;

   always_comb begin
      vis_in   = 1'b1;
      face_in  = FACE_NONE;
      found    = 1'b0;
      cc       = '0;
      rr       = HW'(radius_ff);
      bound    = '0;
      cull_hit = 1'b0;
      if (cull_en_ff) begin
         for (int i = 0; i < NUM_FACES; i++) begin
            cc    = HW'($signed(tail_ff[POS_J].ctr[i/2]));
            bound = ((i & 1) != 0) ? ONE_Q : -ONE_Q;
            if (!((cc + rr > bound) && (cc - rr < bound)) && !found) begin
               cull_hit = ((i & 1) != 0) ? (cc > ONE_Q) : (cc < -ONE_Q);
               if (cull_hit) begin
                  found   = 1'b1;
                  vis_in  = 1'b0;
                  face_in = face_type'(i);
               end
            end
         end
      end
   end

   logic     rsp_visible_ff;
   face_type rsp_face_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tail_ff[POS_J].v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_visible_ff <= vis_in;
         rsp_face_ff    <= face_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_visible   = rsp_visible_ff;
   assign rsp_cull_face = rsp_face_ff;

endmodule
